@@ hdl/mhpq_pkg.sv @@
package mhpq_pkg;

   localparam int OP_W  = 2;
   localparam int ST_W  = 3;
   localparam int ID_W  = 16;
   localparam int KEY_W = 16;
   localparam int OCC_W = 9;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
   localparam logic [OP_W-1:0] OP_POP    = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   localparam logic [ST_W-1:0] ST_OK        = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
   localparam logic [ST_W-1:0] ST_UPD_EMPTY = 3'd2;
   localparam logic [ST_W-1:0] ST_KEY_UP    = 3'd3;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [ST_W-1:0] ST_POP_EMPTY = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  item_id;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [ID_W-1:0]  popped_id;
      logic [KEY_W-1:0] popped_key;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

endpackage

@@ hdl/min_heap_priority_queue_top.sv @@
// Binary min-heap of up to CAPACITY (id, key) words held in one RAM. Requests
// queue in a two-word front buffer; the heap engine serves one at a time.
// Insert walks up the heap with one RAM read and one compare/write per level;
// pop walks down with reads of both children, then a compare/write, per
// level. Decrease-key adds a scan that reads one occupied slot per cycle;
// simple rejections go straight from idle to the done state. Results wait in
// an output register, so the engine stalls only when that register is full.
module min_heap_priority_queue_top
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_word,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_word
);
   logic    cmd_valid, cmd_take, rsp_valid;
   req_type cmd_word;

   mhpq_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_word(req_word), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd_word(cmd_word)
   );

   mhpq_back #(.CAPACITY(CAPACITY)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd_word(cmd_word), .rsp_valid(rsp_valid),
      .rsp_taken(rsp_pop && rsp_valid), .rsp_word(rsp_word)
   );

   assign rsp_empty = !rsp_valid;

`ifndef ASSERT_OFF
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_word.occupancy <= CAPACITY)
      else $error("occupancy beyond capacity");
   a_pop_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.status != ST_OK) |->
      (rsp_word.popped_id == '0 && rsp_word.popped_key == '0))
      else $error("popped fields set on error");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))
      else $error("result changed while waiting");
`endif
endmodule

@@ hdl/mhpq_ram.sv @@
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/mhpq_front.sv @@
module mhpq_front
   import mhpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_word,
   output logic    cmd_valid,
   input  logic    cmd_take,
   output req_type cmd_word
);
   // two-entry queue between front and back
   req_type    q_ff [2];
   req_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, take;

   assign req_full  = (cnt_ff == 2'd2);
   assign push      = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign take      = cmd_take && cmd_valid;
   assign cmd_word  = q_ff[0];

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (take) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = req_word;
         cnt_in          = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule

@@ hdl/mhpq_back.sv @@
module mhpq_back
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_take,
   input  req_type cmd_word,
   output logic    rsp_valid,
   input  logic    rsp_taken,
   output rsp_type rsp_word
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = ID_W + KEY_W;
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_SCAN   = 9'b000000010,
      S_SCANW  = 9'b000000100,
      S_UP_RD  = 9'b000001000,
      S_UP_CMP = 9'b000010000,
      S_DN_RD  = 9'b000100000,
      S_DN_L   = 9'b001000000,
      S_DN_CMP = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  aux_ff, aux_in;
   logic [DW-1:0]  cur_ff, cur_in;
   logic [DW-1:0]  lch_ff, lch_in;
   req_type        cmd_ff, cmd_in;
   rsp_type        out_ff, out_in;
   rsp_type        res_ff, res_in;
   logic           ovalid_ff, ovalid_in;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [DW-1:0]  wr_data, rd_data;
   logic [CW-1:0]  par;
   logic [CW:0]    lpos, rpos, count_x;

   mhpq_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign par     = (pos_ff - CW'(1)) >> 1;
   assign lpos    = {pos_ff, 1'b1};
   assign rpos    = lpos + (CW+1)'(1);
   assign count_x = {1'b0, count_ff};
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = ovalid_ff;
   assign rsp_word  = res_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      aux_in    = aux_ff;
      cur_in    = cur_ff;
      lch_in    = lch_ff;
      cmd_in    = cmd_ff;
      out_in    = out_ff;
      res_in    = res_ff;
      ovalid_in = ovalid_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff[AW-1:0];
      wr_data   = cur_ff;
      rd_addr   = aux_ff[AW-1:0];
      if (rsp_taken) begin
         ovalid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_word;
               out_in = '{status: ST_OK, popped_id: '0, popped_key: '0,
                          occupancy: OCC_W'(count_ff)};
               state_in = S_DONE;
               unique case (cmd_word.op)
                  OP_INSERT: begin
                     if (count_ff == CAP) begin
                        out_in.status = ST_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        out_in.occupancy = OCC_W'(count_in);
                        pos_in   = count_ff;
                        cur_in   = {cmd_word.item_id, cmd_word.key};
                        state_in = S_UP_RD;
                     end
                  end
                  OP_UPDATE: begin
                     if (count_ff == '0) begin
                        out_in.status = ST_UPD_EMPTY;
                     end else begin
                        aux_in   = '0;
                        pos_in   = '0;
                        state_in = S_SCANW;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        out_in.status = ST_POP_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                        out_in.occupancy = OCC_W'(count_in);
                        aux_in   = '0;
                        state_in = S_DN_RD;
                     end
                  end
                  OP_NOP: ;
                  default: ;
               endcase
            end
         end
         S_SCANW: begin
            rd_addr  = pos_ff[AW-1:0];
            pos_in   = pos_ff + CW'(1);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // rd_data holds slot aux_ff; pos_ff is next slot
            rd_addr = pos_ff[AW-1:0];
            if (rd_data[DW-1:KEY_W] == cmd_ff.item_id) begin
               if (cmd_ff.key > rd_data[KEY_W-1:0]) begin
                  out_in.status = ST_KEY_UP;
                  state_in = S_DONE;
               end else begin
                  pos_in   = aux_ff;
                  cur_in   = {cmd_ff.item_id, cmd_ff.key};
                  state_in = S_UP_RD;
               end
            end else if (pos_ff == count_ff) begin
               out_in.status = ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               aux_in = pos_ff;
               pos_in = pos_ff + CW'(1);
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = par[AW-1:0];
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (rd_data[KEY_W-1:0] <= cur_ff[KEY_W-1:0]) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               pos_in   = par;
               state_in = S_UP_RD;
            end
         end
         S_DN_RD: begin
            // first pass reads root then last slot
            if (pos_ff == '0 && aux_ff == '0) begin
               aux_in = CW'(1);
               rd_addr = '0;
               state_in = S_DN_L;
               lch_in = '0;
            end
            if (aux_ff != '0) begin
               if (lpos < count_x) begin
                  rd_addr  = lpos[AW-1:0];
                  state_in = S_DN_L;
               end else begin
                  wr_en    = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_DN_L: begin
            if (aux_ff == CW'(1)) begin
               // rd_data is root
               out_in.popped_id  = rd_data[DW-1:KEY_W];
               out_in.popped_key = rd_data[KEY_W-1:0];
               aux_in   = CW'(2);
               state_in = S_DN_CMP;
               rd_addr  = count_ff[AW-1:0];
               if (count_ff == '0) begin
                  state_in = S_DONE;
               end
            end else begin
               lch_in   = rd_data;
               rd_addr  = rpos[AW-1:0];
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (aux_ff == CW'(2)) begin
               // rd_data is last entry, becomes cur at root
               cur_in   = rd_data;
               aux_in   = CW'(3);
               state_in = S_DN_RD;
            end else begin
               if (rpos < count_x && rd_data[KEY_W-1:0] < lch_ff[KEY_W-1:0] &&
                   rd_data[KEY_W-1:0] < cur_ff[KEY_W-1:0]) begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data;
                  pos_in   = rpos[CW-1:0];
                  state_in = S_DN_RD;
               end else if (lch_ff[KEY_W-1:0] < cur_ff[KEY_W-1:0]) begin
                  wr_en    = 1'b1;
                  wr_data  = lch_ff;
                  pos_in   = lpos[CW-1:0];
                  state_in = S_DN_RD;
               end else begin
                  wr_en    = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!ovalid_ff || rsp_taken) begin
               ovalid_in = 1'b1;
               res_in    = out_ff;
               pos_in    = '0;
               aux_in    = '0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      lch_ff <= lch_in;
      cmd_ff <= cmd_in;
      out_ff <= out_in;
      res_ff <= res_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
         pos_ff    <= '0;
         aux_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
         pos_ff    <= pos_in;
         aux_ff    <= aux_in;
      end
   end
endmodule
